// File: hw/rtl/ipq_pkg.sv
package ipq_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;
    localparam logic [2:0] OP_PEEK   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOUSE  = 2'd3;

    localparam logic [1:0] REG_MAX_FIRST = 2'd0;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  handle;
        logic [31:0] key;
    } t_ipq_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  result_handle;
        logic [31:0] result_key;
        logic [8:0]  count;
    } t_ipq_out;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_TOPKEY,
        S_RDKEY,
        S_RM_A,
        S_RM_B,
        S_RM_C,
        S_UP_A,
        S_UP_B,
        S_UP_C,
        S_UP_END,
        S_DN_A,
        S_DN_B,
        S_DN_C,
        S_DN_D,
        S_FIN,
        S_DONE
    } t_state;

endpackage

// File: hw/rtl/ipq_ram.sv
module ipq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/indexed_priority_queue.sv
// Indexed binary-heap priority queue. Pulse start with an item while busy is
// low; busy stays high until the single result appears on o_result for
// exactly one cycle with o_strobe high, and the receiver must take it then.
// Push, pop, peek, remove, update and read return the handle involved; pop,
// peek and read also return the key. A sift walks the heap level by level,
// each level being position reads, key reads and a compare on the single
// key/handle memory ports. After reset the handle tables are initialized by
// a pass over all CAPACITY entries during which busy stays high;
// configuration writes are taken throughout.
module indexed_priority_queue
    import ipq_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_ipq_in     i_item,
    output logic        o_strobe,
    output t_ipq_out    o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = PW + 2;
    localparam int KW = KEY_WIDTH;

    t_state r_state, n_state;
    t_ipq_in r_in;
    logic [CW-1:0] r_occ, n_occ;
    logic [PW-1:0] r_p, n_p;
    logic [PW-1:0] r_mh, n_mh;
    logic [KW-1:0] r_mk, n_mk;
    logic [PW-1:0] r_hb, n_hb;
    logic [PW-1:0] r_h1, n_h1;
    logic [KW-1:0] r_k1, n_k1;
    logic [PW-1:0] r_clr;
    logic          r_down, n_down;
    logic          r_maxf;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_rh, n_rh;
    logic [31:0]   r_rk, n_rk;

    logic          ph_we, hp_we, ek_we;
    logic [PW-1:0] ph_wa, ph_wd, ph_ra, ph_rd;
    logic [PW-1:0] hp_wa, hp_wd, hp_ra, hp_rd;
    logic [PW-1:0] ek_wa, ek_ra;
    logic [KW-1:0] ek_wd, ek_rd;

    logic          w_full, w_empty, w_inuse, w_more;
    logic [PW-1:0] w_hidx, w_parent, w_last, w_cpos, w_hc;
    logic [XW-1:0] w_c1;
    logic          w_c1_ok, w_c2_ok, w_sel2, w_up_go, w_dn_go;
    logic [KW-1:0] w_kc;

    function automatic logic ahead(input logic maxf, input logic [KW-1:0] a,
                                   input logic [KW-1:0] b);
        ahead = maxf ? (a > b) : (a < b);
    endfunction

    ipq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_ph (
        .i_clk(i_clk), .i_we(ph_we), .i_waddr(ph_wa), .i_wdata(ph_wd),
        .i_raddr(ph_ra), .o_rdata(ph_rd)
    );

    ipq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_hp (
        .i_clk(i_clk), .i_we(hp_we), .i_waddr(hp_wa), .i_wdata(hp_wd),
        .i_raddr(hp_ra), .o_rdata(hp_rd)
    );

    ipq_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_ek (
        .i_clk(i_clk), .i_we(ek_we), .i_waddr(ek_wa), .i_wdata(ek_wd),
        .i_raddr(ek_ra), .o_rdata(ek_rd)
    );

    assign w_hidx   = PW'(r_in.handle);
    assign w_full   = (r_occ == CW'(CAPACITY));
    assign w_empty  = (r_occ == '0);
    assign w_inuse  = (32'(r_in.handle) < 32'(CAPACITY)) && (CW'(hp_rd) < r_occ);
    assign w_last   = PW'(r_occ - CW'(1));
    assign w_more   = (r_p < w_last);
    assign w_parent = PW'((r_p - PW'(1)) >> 1);
    assign w_c1     = (XW'(r_p) << 1) + XW'(1);
    assign w_c1_ok  = (w_c1 < XW'(r_occ));
    assign w_c2_ok  = ((w_c1 + XW'(1)) < XW'(r_occ));
    assign w_sel2   = w_c2_ok && ahead(r_maxf, ek_rd, r_k1);
    assign w_kc     = w_sel2 ? ek_rd : r_k1;
    assign w_hc     = w_sel2 ? r_hb : r_h1;
    assign w_cpos   = w_sel2 ? PW'(w_c1 + XW'(1)) : PW'(w_c1);
    assign w_up_go  = ahead(r_maxf, r_mk, ek_rd);
    assign w_dn_go  = ahead(r_maxf, w_kc, r_mk);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == PW'(CAPACITY - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_LOOK;
            end
            S_LOOK: begin
                priority case (r_in.opcode)
                    OP_PUSH:           n_state = w_full ? S_DONE : S_UP_A;
                    OP_POP, OP_PEEK:   n_state = w_empty ? S_DONE : S_TOPKEY;
                    OP_REMOVE:         n_state = w_inuse ? S_RM_A : S_DONE;
                    OP_UPDATE:         n_state = w_inuse ? S_UP_A : S_DONE;
                    OP_READ:           n_state = w_inuse ? S_RDKEY : S_DONE;
                    default:           n_state = S_DONE;
                endcase
            end
            S_TOPKEY: n_state = (r_in.opcode == OP_POP) ? S_RM_A : S_DONE;
            S_RDKEY:  n_state = S_DONE;
            S_RM_A:   n_state = S_RM_B;
            S_RM_B:   n_state = w_more ? S_RM_C : S_DONE;
            S_RM_C:   n_state = S_UP_A;
            S_UP_A:   n_state = (r_p == '0) ? S_UP_END : S_UP_B;
            S_UP_B:   n_state = S_UP_C;
            S_UP_C:   n_state = w_up_go ? S_UP_A : S_UP_END;
            S_UP_END: n_state = r_down ? S_DN_A : S_FIN;
            S_DN_A:   n_state = w_c1_ok ? S_DN_B : S_FIN;
            S_DN_B:   n_state = S_DN_C;
            S_DN_C:   n_state = S_DN_D;
            S_DN_D:   n_state = w_dn_go ? S_DN_A : S_FIN;
            S_FIN:    n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ph_we = 1'b0; ph_wa = '0; ph_wd = '0; ph_ra = '0;
        hp_we = 1'b0; hp_wa = '0; hp_wd = '0; hp_ra = '0;
        ek_we = 1'b0; ek_wa = '0; ek_wd = '0; ek_ra = '0;
        n_occ = r_occ; n_p = r_p; n_mh = r_mh; n_mk = r_mk;
        n_hb = r_hb; n_h1 = r_h1; n_k1 = r_k1; n_down = r_down;
        n_status = r_status; n_rh = r_rh; n_rk = r_rk;
        unique case (r_state)
            S_CLEAR: begin
                ph_we = 1'b1; ph_wa = r_clr; ph_wd = r_clr;
                hp_we = 1'b1; hp_wa = r_clr; hp_wd = r_clr;
            end
            S_IDLE: begin
                ph_ra    = (i_item.opcode == OP_PUSH) ? PW'(r_occ) : '0;
                hp_ra    = PW'(i_item.handle);
                n_status = ST_OK;
                n_rh     = '0;
                n_rk     = '0;
                n_down   = 1'b0;
            end
            S_LOOK: begin
                priority case (r_in.opcode)
                    OP_PUSH: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            ek_we = 1'b1; ek_wa = ph_rd; ek_wd = KW'(r_in.key);
                            n_mh  = ph_rd;
                            n_mk  = KW'(r_in.key);
                            n_p   = PW'(r_occ);
                            n_occ = r_occ + CW'(1);
                            n_rh  = 8'(ph_rd);
                        end
                    end
                    OP_POP, OP_PEEK: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            ek_ra = ph_rd;
                            n_hb  = ph_rd;
                            n_rh  = 8'(ph_rd);
                        end
                    end
                    OP_REMOVE, OP_UPDATE, OP_READ: begin
                        n_rh  = r_in.handle;
                        n_p   = hp_rd;
                        n_hb  = w_hidx;
                        ek_ra = w_hidx;
                        if (!w_inuse) begin
                            n_status = ST_NOUSE;
                        end else if (r_in.opcode == OP_UPDATE) begin
                            ek_we  = 1'b1; ek_wa = w_hidx; ek_wd = KW'(r_in.key);
                            n_mh   = w_hidx;
                            n_mk   = KW'(r_in.key);
                            n_down = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_TOPKEY: begin
                n_rk = 32'(ek_rd);
                n_p  = '0;
            end
            S_RDKEY: begin
                n_rk = 32'(ek_rd);
            end
            S_RM_A: begin
                ph_ra = w_last;
            end
            S_RM_B: begin
                ph_we = 1'b1; ph_wa = w_last; ph_wd = r_hb;
                hp_we = 1'b1; hp_wa = r_hb;   hp_wd = w_last;
                n_occ = r_occ - CW'(1);
                n_mh  = ph_rd;
                ek_ra = ph_rd;
            end
            S_RM_C: begin
                n_mk   = ek_rd;
                n_down = 1'b1;
            end
            S_UP_A: begin
                ph_ra = w_parent;
            end
            S_UP_B: begin
                n_hb  = ph_rd;
                ek_ra = ph_rd;
            end
            S_UP_C: begin
                if (w_up_go) begin
                    ph_we = 1'b1; ph_wa = r_p;  ph_wd = r_hb;
                    hp_we = 1'b1; hp_wa = r_hb; hp_wd = r_p;
                    n_p   = w_parent;
                end
            end
            S_UP_END: begin
            end
            S_DN_A: begin
                ph_ra = PW'(w_c1);
            end
            S_DN_B: begin
                n_h1  = ph_rd;
                ek_ra = ph_rd;
                ph_ra = PW'(w_c1 + XW'(1));
            end
            S_DN_C: begin
                n_k1  = ek_rd;
                n_hb  = ph_rd;
                ek_ra = ph_rd;
            end
            S_DN_D: begin
                if (w_dn_go) begin
                    ph_we = 1'b1; ph_wa = r_p;  ph_wd = w_hc;
                    hp_we = 1'b1; hp_wa = w_hc; hp_wd = r_p;
                    n_p   = w_cpos;
                end
            end
            S_FIN: begin
                ph_we = 1'b1; ph_wa = r_p;  ph_wd = r_mh;
                hp_we = 1'b1; hp_wa = r_mh; hp_wd = r_p;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_occ   <= '0;
            r_maxf  <= 1'b0;
            r_down  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_down  <= n_down;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + PW'(1);
            end
            if (psel && penable && pwrite && paddr == REG_MAX_FIRST) begin
                r_maxf <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_in <= i_item;
        end
        r_p      <= n_p;
        r_mh     <= n_mh;
        r_mk     <= n_mk;
        r_hb     <= n_hb;
        r_h1     <= n_h1;
        r_k1     <= n_k1;
        r_status <= n_status;
        r_rh     <= n_rh;
        r_rk     <= n_rk;
    end

    assign busy                   = (r_state != S_IDLE);
    assign o_strobe               = (r_state == S_DONE);
    assign o_result.status        = r_status;
    assign o_result.result_handle = r_rh;
    assign o_result.result_key    = r_rk;
    assign o_result.count         = 9'(r_occ);
    assign pready                 = 1'b1;
    assign prdata                 = (paddr == REG_MAX_FIRST) ? {31'b0, r_maxf} : '0;

endmodule

// File: sim/indexed_priority_queue_tb.sv
module indexed_priority_queue_tb;
    import ipq_pkg::*;

    class heap_scoreboard;
        logic [7:0]  pos_handle [256];
        logic [7:0]  handle_pos [256];
        logic [31:0] handle_key [256];
        int          occ;
        bit          max_first;
        t_ipq_out    expected_q [$];
        int          errors;

        function void clear();
            for (int i = 0; i < 256; i++) begin
                pos_handle[i] = 8'(i);
                handle_pos[i] = 8'(i);
                handle_key[i] = '0;
            end
            occ = 0;
            max_first = 0;
            errors = 0;
        endfunction

        function bit ahead(logic [31:0] a, logic [31:0] b);
            return max_first ? (a > b) : (a < b);
        endfunction

        function logic [31:0] key_at(int p);
            return handle_key[pos_handle[p]];
        endfunction

        function void swap_pos(int a, int b);
            logic [7:0] ha;
            logic [7:0] hb;
            ha = pos_handle[a];
            hb = pos_handle[b];
            pos_handle[a] = hb;
            pos_handle[b] = ha;
            handle_pos[ha] = 8'(b);
            handle_pos[hb] = 8'(a);
        endfunction

        function int sift_up(int p);
            int parent;
            while (p > 0) begin
                parent = (p - 1) / 2;
                if (!ahead(key_at(p), key_at(parent))) break;
                swap_pos(p, parent);
                p = parent;
            end
            return p;
        endfunction

        function void sift_down(int p);
            int c;
            while (2 * p + 1 < occ) begin
                c = 2 * p + 1;
                if (c + 1 < occ && ahead(key_at(c + 1), key_at(c))) c++;
                if (!ahead(key_at(c), key_at(p))) break;
                swap_pos(c, p);
                p = c;
            end
        endfunction

        function void take_out(int p);
            swap_pos(p, occ - 1);
            occ--;
            if (p < occ) sift_down(sift_up(p));
        endfunction

        function void note_item(t_ipq_in it);
            t_ipq_out r;
            logic [7:0] h;
            bit in_use;
            r = '0;
            h = it.handle;
            in_use = handle_pos[h] < occ;
            case (it.opcode)
                OP_PUSH: begin
                    if (occ >= 256) begin
                        r.status = ST_FULL;
                    end else begin
                        h = pos_handle[occ];
                        handle_pos[h] = 8'(occ);
                        handle_key[h] = it.key;
                        occ++;
                        void'(sift_up(occ - 1));
                        r.result_handle = h;
                    end
                end
                OP_POP, OP_PEEK: begin
                    if (occ == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.result_handle = pos_handle[0];
                        r.result_key = handle_key[pos_handle[0]];
                        if (it.opcode == OP_POP) take_out(0);
                    end
                end
                OP_REMOVE, OP_UPDATE, OP_READ: begin
                    r.result_handle = h;
                    if (!in_use) begin
                        r.status = ST_NOUSE;
                    end else if (it.opcode == OP_REMOVE) begin
                        take_out(handle_pos[h]);
                    end else if (it.opcode == OP_UPDATE) begin
                        handle_key[h] = it.key;
                        sift_down(sift_up(handle_pos[h]));
                    end else begin
                        r.result_key = handle_key[h];
                    end
                end
                default: ;
            endcase
            r.count = 9'(occ);
            expected_q.push_back(r);
        endfunction

        function void check_result(t_ipq_out got);
            t_ipq_out exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status || got.result_handle !== exp_r.result_handle ||
                got.result_key !== exp_r.result_key || got.count !== exp_r.count) begin
                $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_ipq_in     i_item;
    logic        o_strobe;
    t_ipq_out    o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    heap_scoreboard sb;
    int unsigned    cycles;

    indexed_priority_queue u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) sb.check_result(o_result);
    end

    initial begin
        wait (cycles > 500000);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(t_ipq_in it, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_item = it;
        start = 1;
        while (busy) @(negedge i_clk);
        sb.note_item(it);
        @(posedge i_clk);
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] h, logic [31:0] k);
        t_ipq_in it;
        it.opcode = op;
        it.handle = h;
        it.key = k;
        send_item(it, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 0;
        while (sb.expected_q.size() > 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_max_first(bit v);
        @(negedge i_clk);
        psel = 1;
        penable = 0;
        pwrite = 1;
        paddr = 2'(REG_MAX_FIRST << 2);
        pwdata = {31'd0, v};
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.max_first = v;
        @(negedge i_clk);
        psel = 0;
        penable = 0;
        pwrite = 0;
    endtask

    function automatic logic [31:0] pick_key();
        return ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
    endfunction

    function automatic logic [7:0] pick_handle();
        if (sb.occ > 0 && $urandom_range(0, 9) < 8)
            return sb.pos_handle[$urandom_range(0, sb.occ - 1)];
        return 8'($urandom);
    endfunction

    task automatic random_phase(int n);
        int w;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(0, 99);
            if (sb.occ > 120 && w < 35) w = w + 35;
            if (w < 35) op = OP_PUSH;
            else if (w < 50) op = OP_POP;
            else if (w < 62) op = OP_REMOVE;
            else if (w < 77) op = OP_UPDATE;
            else if (w < 88) op = OP_READ;
            else if (w < 96) op = OP_PEEK;
            else op = 3'($urandom_range(6, 7));
            send_op(op, pick_handle(), pick_key());
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        cycles = 0;
        i_rst_n = 0;
        start = 0;
        i_item = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        send_op(OP_PEEK, 8'd0, 32'd0);
        send_op(OP_POP, 8'hff, 32'hffffffff);
        send_op(OP_READ, 8'd0, 32'd0);
        send_op(OP_REMOVE, 8'hff, 32'd0);
        send_op(OP_UPDATE, 8'd7, 32'd5);
        send_op(3'd6, 8'hff, 32'hffffffff);
        send_op(3'd7, 8'h5a, 32'h12345678);
        send_op(OP_PUSH, 8'd0, 32'hffffffff);
        send_op(OP_PUSH, 8'd0, 32'd0);
        send_op(OP_PUSH, 8'd0, 32'd0);
        send_op(OP_PUSH, 8'd0, 32'd100);
        send_op(OP_PUSH, 8'd0, 32'd50);
        send_op(OP_PEEK, 8'd0, 32'd0);
        send_op(OP_READ, 8'd0, 32'd0);
        send_op(OP_UPDATE, 8'd0, 32'd75);
        send_op(OP_UPDATE, 8'd3, 32'd0);
        send_op(OP_REMOVE, 8'd1, 32'd0);
        send_op(OP_READ, 8'd1, 32'd0);
        send_op(OP_POP, 8'd0, 32'd0);
        send_op(OP_POP, 8'd0, 32'd0);
        send_op(OP_PUSH, 8'd0, 32'd9);
        send_op(OP_REMOVE, 8'd4, 32'd0);
        wait_drained();

        write_max_first(1);
        random_phase(150);
        while (sb.occ < 256) send_op(OP_PUSH, 8'd0, pick_key());
        send_op(OP_PUSH, 8'd0, 32'd1);
        send_op(OP_READ, pick_handle(), 32'd0);
        wait_drained();

        write_max_first(0);
        while (sb.occ > 0) send_op(OP_POP, 8'd0, 32'd0);
        random_phase(120);
        wait_drained();

        write_max_first(1);
        random_phase(60);
        wait_drained();
        write_max_first(0);
        random_phase(60);
        wait_drained();

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
